@@ rtl/baro_sensor_sequencer_compensation_unit_defines.svh @@
// Assertion macros shared by the checker of the barometric sensor sequencer.
`ifndef BARO_SENSOR_SEQUENCER_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_SENSOR_SEQUENCER_COMPENSATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bssc_pkg.sv @@
// Shared types, constants and functions of the barometric sensor sequencer.
package bssc_pkg;

	localparam int unsigned WordW   = 16;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned PhaseW  = 3;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CalibN  = 4;
	localparam int unsigned CalibIdxW = $clog2(CalibN);
	localparam int unsigned PressW  = 18;

	localparam logic [PhaseW-1:0] PhaseInit  = 3'd0;
	localparam logic [PhaseW-1:0] PhaseLastInit = 3'd3;
	localparam logic [PhaseW-1:0] PhaseRaw   = 3'd4;
	localparam logic [PhaseW-1:0] PhaseTemp  = 3'd5;

	localparam logic [ByteW-1:0] CmdInitByte = 8'h1D;
	localparam logic [ByteW-1:0] CmdMeasByte = 8'h0F;

	localparam logic [CfgIdxW-1:0] CfgUsePreset   = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgPresetOne   = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgPresetTwo   = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgPresetThree = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgPresetFour  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_COMP,
		ST_PROD,
		ST_SCALE,
		ST_DONE
	} bssc_state_t;

	typedef struct packed {
		logic                 capture;
		logic                 calib_we;
		logic [CalibIdxW-1:0] calib_idx;
		logic                 raw_we;
		logic                 preset_ld;
		logic                 out_load;
		logic                 res_valid;
		logic [PhaseW-1:0]    phase;
		logic                 reading;
	} bssc_cmd_t;

	typedef struct packed {
		logic use_preset;
	} bssc_stat_t;

	function automatic logic [ByteW-1:0] phase_cmd(input logic [PhaseW-1:0] phase);
		logic [ByteW-1:0] code;
		case (phase)
			3'd0: code = 8'h50;
			3'd1: code = 8'h60;
			3'd2: code = 8'h90;
			3'd3: code = 8'hA0;
			3'd4: code = 8'h40;
			3'd5: code = 8'h20;
			default: code = '0;
		endcase
		return code;
	endfunction

endpackage

@@ rtl/bssc_ctrl.sv @@
// Sequencer state machine: transfer phases, handshakes and datapath commands.
module bssc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                restart,
	output logic                out_valid,
	input  logic                out_stall,
	input  bssc_pkg::bssc_stat_t stat,
	output bssc_pkg::bssc_cmd_t  cmd
);
	import bssc_pkg::*;

	bssc_state_t       state_q, state_d;
	logic [PhaseW-1:0] phase_q, phase_d;
	logic              reading_q, reading_d;
	logic              pend_valid_q, pend_valid_d;
	logic              out_valid_q;
	logic              accept;
	logic              out_free;
	logic              is_comp;

	assign out_free = !out_valid_q || !out_stall;
	assign is_comp  = !restart && reading_q && (phase_q == PhaseTemp);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = is_comp ? ST_MUL : ST_DONE;
				end
			end
			ST_MUL:   state_d = ST_COMP;
			ST_COMP:  state_d = ST_PROD;
			ST_PROD:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		phase_d      = phase_q;
		reading_d    = reading_q;
		pend_valid_d = pend_valid_q;
		if (accept) begin
			pend_valid_d = is_comp;
			if (restart) begin
				reading_d = 1'b0;
				phase_d   = stat.use_preset ? PhaseRaw : PhaseInit;
			end else begin
				reading_d = !reading_q;
				if (reading_q) begin
					phase_d = (phase_q >= PhaseTemp) ? PhaseRaw : phase_q + 3'd1;
				end
			end
		end
	end

	always_comb begin
		accept        = in_valid && (state_q == ST_IDLE);
		in_stall      = (state_q != ST_IDLE);
		cmd.capture   = accept;
		cmd.calib_we  = accept && !restart && reading_q && (phase_q <= PhaseLastInit);
		cmd.calib_idx = phase_q[CalibIdxW-1:0];
		cmd.raw_we    = accept && !restart && reading_q && (phase_q == PhaseRaw);
		cmd.preset_ld = accept && restart && stat.use_preset;
		cmd.out_load  = (state_q == ST_DONE) && out_free;
		cmd.res_valid = pend_valid_q;
		cmd.phase     = phase_q;
		cmd.reading   = reading_q;
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PhaseInit;
			reading_q    <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			reading_q    <= reading_d;
			pend_valid_q <= pend_valid_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/bssc_dpath.sv @@
// Datapath: configuration, calibration store, compensation pipeline and output word.
module bssc_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bssc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bssc_pkg::WordW-1:0]    cfg_data,
	input  logic [bssc_pkg::WordW-1:0]    rx_word,
	input  bssc_pkg::bssc_cmd_t           cmd,
	output bssc_pkg::bssc_stat_t          stat,
	output logic [bssc_pkg::ByteW-1:0]    tx_first,
	output logic [bssc_pkg::ByteW-1:0]    tx_second,
	output logic                          read_clock_phase,
	output logic                          result_valid,
	output logic [bssc_pkg::PressW-1:0]   pressure_value,
	output logic [bssc_pkg::WordW-1:0]    temperature_value
);
	import bssc_pkg::*;

	logic              use_preset_q;
	logic [WordW-1:0]  preset_q [CalibN];
	logic [WordW-1:0]  calib_q  [CalibN];
	logic [WordW-1:0]  raw_q;

	logic [14:0] c1;
	logic [11:0] c2;
	logic [9:0]  c3;
	logic [9:0]  c4;
	logic [10:0] c5;
	logic [5:0]  c6;
	logic [WordW-1:0] ut1;

	logic signed [15:0] dt_s1;
	logic signed [23:0] pt_s2;
	logic signed [26:0] po_s2;
	logic signed [26:0] ps_s2;
	logic [15:0]        t_s3;
	logic [15:0]        off_s3;
	logic [31:0]        sens_s3;
	logic [31:0]        prod_s4;
	logic [22:0]        x100_s5;

	logic signed [23:0] dt24, c6k24, pt_n, qt;
	logic signed [26:0] dt27, c4k27, c3k27, po_n, ps_n, qo, qs;
	logic [6:0]         c6k;
	logic [31:0]        dd;
	logic [15:0]        x;

	assign c1 = calib_q[0][15:1];
	assign c2 = {calib_q[2][5:0], calib_q[3][5:0]};
	assign c3 = calib_q[3][15:6];
	assign c4 = calib_q[2][15:6];
	assign c5 = {calib_q[0][0], calib_q[1][15:6]};
	assign c6 = calib_q[1][5:0];
	assign ut1 = {2'b00, c5, 3'b000} + 16'd20224;

	assign stat.use_preset = use_preset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_preset_q <= 1'b0;
			for (int i = 0; i < CalibN; i++) begin
				preset_q[i] <= '0;
				calib_q[i]  <= '0;
			end
			raw_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CfgUsePreset:   use_preset_q <= cfg_data[0];
					CfgPresetOne:   preset_q[0]  <= cfg_data;
					CfgPresetTwo:   preset_q[1]  <= cfg_data;
					CfgPresetThree: preset_q[2]  <= cfg_data;
					CfgPresetFour:  preset_q[3]  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.preset_ld) begin
				for (int i = 0; i < CalibN; i++) begin
					calib_q[i] <= preset_q[i];
				end
			end else if (cmd.calib_we) begin
				calib_q[cmd.calib_idx] <= rx_word;
			end
			if (cmd.raw_we) begin
				raw_q <= rx_word;
			end
		end
	end

	always_comb begin
		c6k   = {1'b0, c6} + 7'd50;
		dt24  = {{8{dt_s1[15]}}, dt_s1};
		c6k24 = {17'b0, c6k};
		pt_n  = dt24 * c6k24;
		dt27  = {{11{dt_s1[15]}}, dt_s1};
		c4k27 = {17'b0, c4} - 27'sd512;
		c3k27 = {17'b0, c3};
		po_n  = dt27 * c4k27;
		ps_n  = dt27 * c3k27;
	end

	always_comb begin
		qt = (pt_s2 + (pt_s2[23] ? 24'sd1023 : 24'sd0)) >>> 10;
		qo = (po_s2 + (po_s2[26] ? 27'sd4095 : 27'sd0)) >>> 12;
		qs = (ps_s2 + (ps_s2[26] ? 27'sd1023 : 27'sd0)) >>> 10;
		dd = {16'b0, raw_q} - 32'd7168;
		x  = prod_s4[29:14] - off_s3;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dt_s1 <= rx_word - ut1;
		end
		pt_s2   <= pt_n;
		po_s2   <= po_n;
		ps_s2   <= ps_n;
		t_s3    <= qt[15:0] + 16'd200;
		off_s3  <= {2'b00, c2, 2'b00} + qo[15:0];
		sens_s3 <= {17'b0, c1} + {{5{qs[26]}}, qs} + 32'd24576;
		prod_s4 <= sens_s3 * dd;
		x100_s5 <= {7'b0, x} * 23'd100;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.reading) begin
				tx_first         <= '0;
				tx_second        <= '0;
				read_clock_phase <= 1'b1;
			end else begin
				tx_first         <= (cmd.phase <= PhaseLastInit) ? CmdInitByte : CmdMeasByte;
				tx_second        <= phase_cmd(cmd.phase);
				read_clock_phase <= 1'b0;
			end
			result_valid <= cmd.res_valid;
			if (cmd.res_valid) begin
				pressure_value    <= x100_s5[22:5] + 18'd25000;
				temperature_value <= t_s3;
			end else begin
				pressure_value    <= '0;
				temperature_value <= '0;
			end
		end
	end

endmodule

@@ rtl/baro_sensor_sequencer_compensation_unit.sv @@
// Top level of the barometric sensor sequencer with integer compensation.
//
//   Channel   Direction  Handshake             Word
//   input     in         in_valid / in_stall   rx_word, restart
//   output    out        out_valid / out_stall tx_first, tx_second, read_clock_phase,
//                                              result_valid, pressure_value,
//                                              temperature_value
//   config    in         cfg_we                cfg_index, cfg_data
//
// A command, calibration or raw pressure word goes from acceptance straight to the DONE
// state, which loads it into the output register; a temperature read first passes the
// five-stage compensation chain through the MUL, COMP, PROD and SCALE states.
// One word is computed at a time; the next is taken the cycle after its result is
// registered. The output register holds its word while out_stall is high.
// Asynchronous reset returns the sequence to the first init phase with zeroed
// calibration words.
module baro_sensor_sequencer_compensation_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bssc_pkg::WordW-1:0]    rx_word,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bssc_pkg::ByteW-1:0]    tx_first,
	output logic [bssc_pkg::ByteW-1:0]    tx_second,
	output logic                          read_clock_phase,
	output logic                          result_valid,
	output logic [bssc_pkg::PressW-1:0]   pressure_value,
	output logic [bssc_pkg::WordW-1:0]    temperature_value,
	input  logic                          cfg_we,
	input  logic [bssc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bssc_pkg::WordW-1:0]    cfg_data
);
	import bssc_pkg::*;

	bssc_cmd_t  cmd;
	bssc_stat_t stat;

	bssc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.restart   (restart),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bssc_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.rx_word           (rx_word),
		.cmd               (cmd),
		.stat              (stat),
		.tx_first          (tx_first),
		.tx_second         (tx_second),
		.read_clock_phase  (read_clock_phase),
		.result_valid      (result_valid),
		.pressure_value    (pressure_value),
		.temperature_value (temperature_value)
	);

endmodule

@@ rtl/bssc_checker.sv @@
// Port-level checker of the barometric sensor sequencer and its bind.
`include "baro_sensor_sequencer_compensation_unit_defines.svh"

module bssc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [bssc_pkg::ByteW-1:0]    tx_first,
	input  logic [bssc_pkg::ByteW-1:0]    tx_second,
	input  logic                          read_clock_phase,
	input  logic                          result_valid,
	input  logic [bssc_pkg::PressW-1:0]   pressure_value,
	input  logic [bssc_pkg::WordW-1:0]    temperature_value
);
	import bssc_pkg::*;

	`BSSC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "Input taken again before the result was registered.")

	`BSSC_ASSERT_NOW(a_result_follows_temp, clk, arst_n, out_valid && result_valid, tx_first == CmdMeasByte && tx_second == phase_cmd(PhaseRaw) && !read_clock_phase, "A fresh result must be followed by the pressure command.")

	`BSSC_ASSERT_NOW(a_read_bytes_zero, clk, arst_n, out_valid && read_clock_phase, tx_first == 8'h00 && tx_second == 8'h00, "A read transfer must send zero bytes.")

	`BSSC_ASSERT_NOW(a_stale_fields_zero, clk, arst_n, out_valid && !result_valid, pressure_value == 18'd0 && temperature_value == 16'd0, "Pressure and temperature must be zero without a fresh result.")

	`BSSC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pressure_value) && $stable(tx_second), "Stalled output word changed.")

endmodule

bind baro_sensor_sequencer_compensation_unit bssc_checker u_bssc_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench of the barometric sensor sequencer with integer compensation.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bssc_pkg::*;

	localparam logic [ByteW-1:0] CodeCalibOne   = 8'h50;
	localparam logic [ByteW-1:0] CodeCalibTwo   = 8'h60;
	localparam logic [ByteW-1:0] CodeCalibThree = 8'h90;
	localparam logic [ByteW-1:0] CodeCalibFour  = 8'hA0;
	localparam logic [ByteW-1:0] CodePressure   = 8'h40;
	localparam logic [ByteW-1:0] CodeTemperature = 8'h20;

	typedef struct packed {
		logic [WordW-1:0] rx_word;
		logic             restart;
	} transfer_t;

	typedef struct packed {
		logic [ByteW-1:0]  tx_first;
		logic [ByteW-1:0]  tx_second;
		logic              read_clock_phase;
		logic              fresh;
		logic [PressW-1:0] pressure;
		logic [WordW-1:0]  temperature;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [WordW-1:0] rx_word = '0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ByteW-1:0] tx_first;
	logic [ByteW-1:0] tx_second;
	logic read_clock_phase;
	logic result_valid;
	logic [PressW-1:0] pressure_value;
	logic [WordW-1:0] temperature_value;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [WordW-1:0] cfg_data = '0;

	baro_sensor_sequencer_compensation_unit u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_word           (rx_word),
		.restart           (restart),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.tx_first          (tx_first),
		.tx_second         (tx_second),
		.read_clock_phase  (read_clock_phase),
		.result_valid      (result_valid),
		.pressure_value    (pressure_value),
		.temperature_value (temperature_value),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// Shadow of the sequencer state and its registers.
	logic              preset_on = 1'b0;
	logic [WordW-1:0]  preset_mem [CalibN] = '{default: '0};
	logic [WordW-1:0]  calib_mem [CalibN] = '{default: '0};
	logic [PhaseW-1:0] seq_phase = PhaseInit;
	logic              seq_reading = 1'b0;
	logic [WordW-1:0]  raw_press = '0;

	transfer_t transfers_pending [$];
	reply_t    replies_due [$];
	int        mismatches = 0;
	int        words_taken = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        seg_left = 0;
	int        seg_mode = 0;
	int        holdoff_left = 0;
	bit        holdoff_done = 1'b0;

	function automatic void compensate_reading(input logic [WordW-1:0] d2,
			output logic [PressW-1:0] press, output logic [WordW-1:0] temp);
		int c1, c2, c3, c4, c6, dt, t, off;
		int unsigned c5, ut1, sens, dd, prod, x;
		shortint dt16, off16;
		c1 = int'(calib_mem[0] >> 1);
		c2 = int'({calib_mem[2][5:0], calib_mem[3][5:0]});
		c3 = int'(calib_mem[3][15:6]);
		c4 = int'(calib_mem[2][15:6]);
		c5 = 32'({calib_mem[0][0], calib_mem[1][15:6]});
		c6 = int'(calib_mem[1][5:0]);
		ut1 = ((c5 << 3) + 32'd20224) & 32'hFFFF;
		dt16 = d2 - ut1[15:0];
		dt = int'(dt16);
		t = 200 + (dt * (c6 + 50)) / 1024;
		off16 = shortint'(c2 * 4 + ((c4 - 512) * dt) / 4096);
		off = int'(off16);
		sens = c1 + (c3 * dt) / 1024 + 24576;
		dd = 32'(raw_press) - 32'd7168;
		prod = sens * dd;
		x = ((prod / 32'd16384) - $unsigned(off)) & 32'hFFFF;
		temp = t[15:0];
		press = 18'(((x * 32'd100) >> 5) + 32'd25000);
	endfunction

	function automatic reply_t advance_sequencer(input transfer_t tr);
		reply_t rep;
		int i;
		rep = '0;
		if (tr.restart) begin
			seq_phase = PhaseInit;
			seq_reading = 1'b0;
			if (preset_on) begin
				for (i = 0; i < CalibN; i++)
					calib_mem[i] = preset_mem[i];
				seq_phase = PhaseRaw;
			end
		end else begin
			if (seq_reading) begin
				if (seq_phase <= PhaseLastInit) begin
					calib_mem[seq_phase[1:0]] = tr.rx_word;
				end else if (seq_phase == PhaseRaw) begin
					raw_press = tr.rx_word;
				end else if (seq_phase == PhaseTemp) begin
					compensate_reading(tr.rx_word, rep.pressure, rep.temperature);
					rep.fresh = 1'b1;
				end
				if (seq_phase >= PhaseTemp)
					seq_phase = PhaseRaw;
				else
					seq_phase = seq_phase + 3'd1;
			end
			seq_reading = !seq_reading;
		end
		if (seq_reading) begin
			rep.read_clock_phase = 1'b1;
		end else begin
			rep.tx_first = (seq_phase <= PhaseLastInit) ? CmdInitByte : CmdMeasByte;
			case (seq_phase)
				3'd0: rep.tx_second = CodeCalibOne;
				3'd1: rep.tx_second = CodeCalibTwo;
				3'd2: rep.tx_second = CodeCalibThree;
				3'd3: rep.tx_second = CodeCalibFour;
				PhaseRaw: rep.tx_second = CodePressure;
				PhaseTemp: rep.tx_second = CodeTemperature;
				default: rep.tx_second = '0;
			endcase
		end
		return rep;
	endfunction

	function automatic void queue_transfer(input logic [WordW-1:0] rx, input logic rs);
		transfer_t tr;
		tr.rx_word = rx;
		tr.restart = rs;
		transfers_pending.push_back(tr);
	endfunction

	task automatic queue_random(input int count);
		logic [WordW-1:0] rx;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(9))
				0: rx = '0;
				1: rx = '1;
				default: rx = 16'($urandom);
			endcase
			queue_transfer(rx, $urandom_range(99) < 3);
		end
	endtask

	task automatic wait_drained();
		while (transfers_pending.size() != 0 || in_valid || replies_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CfgUsePreset:   preset_on = data[0];
			CfgPresetOne:   preset_mem[0] = data;
			CfgPresetTwo:   preset_mem[1] = data;
			CfgPresetThree: preset_mem[2] = data;
			CfgPresetFour:  preset_mem[3] = data;
			default: ;
		endcase
	endtask

	task automatic write_presets(input logic use_it, input logic [WordW-1:0] w0,
			input logic [WordW-1:0] w1, input logic [WordW-1:0] w2,
			input logic [WordW-1:0] w3);
		write_register(CfgUsePreset, {15'd0, use_it});
		write_register(CfgPresetOne, w0);
		write_register(CfgPresetTwo, w1);
		write_register(CfgPresetThree, w2);
		write_register(CfgPresetFour, w3);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic flag_mismatch(input string field, input int unsigned want_v,
			input int unsigned got_v);
		$display("%0t: %s expected %0h got %0h", $time, field, want_v, got_v);
		mismatches++;
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin : driver
		transfer_t nxt;
		bit offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offer = in_valid;
			if (in_valid && !in_stall) begin
				nxt.rx_word = rx_word;
				nxt.restart = restart;
				replies_due.push_back(advance_sequencer(nxt));
				words_taken++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (transfers_pending.size() != 0) begin
					nxt = transfers_pending.pop_front();
					rx_word <= nxt.rx_word;
					restart <= nxt.restart;
					offer = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			in_valid <= offer;
		end
	end

	always @(posedge clk) begin : monitor
		reply_t got, want;
		bit hold;
		if (arst_n && out_valid && !out_stall) begin
			got.tx_first = tx_first;
			got.tx_second = tx_second;
			got.read_clock_phase = read_clock_phase;
			got.fresh = result_valid;
			got.pressure = pressure_value;
			got.temperature = temperature_value;
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %0h", $time, got);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (got.tx_first !== want.tx_first)
					flag_mismatch("tx_first", want.tx_first, got.tx_first);
				if (got.tx_second !== want.tx_second)
					flag_mismatch("tx_second", want.tx_second, got.tx_second);
				if (got.read_clock_phase !== want.read_clock_phase)
					flag_mismatch("read_clock_phase", want.read_clock_phase,
						got.read_clock_phase);
				if (got.fresh !== want.fresh)
					flag_mismatch("result_valid", want.fresh, got.fresh);
				if (got.pressure !== want.pressure)
					flag_mismatch("pressure_value", want.pressure, got.pressure);
				if (got.temperature !== want.temperature)
					flag_mismatch("temperature_value", want.temperature, got.temperature);
			end
		end
		// A single long hold-off lets the block fill up and stall its input.
		if (holdoff_left > 0) begin
			holdoff_left--;
			hold = 1'b1;
		end else if (!holdoff_done && words_taken >= 700) begin
			holdoff_done = 1'b1;
			holdoff_left = 300;
			hold = 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_mode = $urandom_range(2);
				seg_left = $urandom_range(10, 80);
			end else begin
				seg_left--;
			end
			case (seg_mode)
				0: hold = 1'b0;
				1: hold = ($urandom_range(3) == 0);
				default: hold = ($urandom_range(9) < 7);
			endcase
		end
		out_stall <= hold;
	end

	initial begin : main
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Calibration words at their extremes, then both raw extremes.
		queue_transfer(16'h1234, 1'b0);
		queue_transfer(16'hFFFF, 1'b0);
		queue_transfer(16'hFFFF, 1'b0);
		queue_transfer(16'h0000, 1'b0);
		queue_transfer(16'h0000, 1'b0);
		queue_transfer(16'hFFFF, 1'b0);
		queue_transfer(16'hABCD, 1'b0);
		queue_transfer(16'h0000, 1'b0);
		queue_transfer(16'hFFFF, 1'b0);
		queue_transfer(16'h0000, 1'b0);
		queue_transfer(16'h0000, 1'b0);
		queue_transfer(16'hFFFF, 1'b0);
		queue_transfer(16'h5555, 1'b0);
		queue_transfer(16'hFFFF, 1'b0);
		queue_transfer(16'hFFFF, 1'b0);
		queue_transfer(16'hAAAA, 1'b0);
		queue_transfer(16'h0000, 1'b0);
		queue_transfer(16'hFFFF, 1'b0);
		queue_transfer(16'h0F0F, 1'b1);
		queue_transfer(16'hFFFF, 1'b1);
		queue_random(400);
		wait_drained();

		write_presets(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_transfer(16'($urandom), 1'b1);
		queue_random(300);
		wait_drained();

		write_presets(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		queue_transfer(16'($urandom), 1'b1);
		queue_random(300);
		wait_drained();

		write_presets(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		queue_transfer(16'($urandom), 1'b1);
		queue_random(400);
		wait_drained();

		write_presets(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		queue_transfer(16'($urandom), 1'b1);
		queue_random(400);
		wait_drained();

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
